### rtl/core/nnt_pkg.sv
package nnt_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_CITIES_DEF = 16;
    localparam int DIST_BITS_DEF  = 16;

    // Fixed field widths on the ports
    localparam int CITY_PORT_W  = 4;
    localparam int LEG_PORT_W   = 16;
    localparam int DIST_PORT_W  = 16;
    localparam int TOTAL_W      = 21;
    localparam int COUNT_W      = 5;
    localparam int COUNT_EXT_W  = 6;     // holds any city count up to 63

    localparam logic [COUNT_W-1:0] CITY_COUNT_RESET = 5'd16;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX        = {TOTAL_W{1'b1}};

    // Beat layouts
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    // Commands carried in s_tuser
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Control from the sequencer to the shared compare unit
    typedef struct packed {
        logic clear;
        logic cand_valid;
    } nnt_scan_ctl_t;

endpackage

### rtl/core/nearest_neighbour_tour.sv
// Greedy nearest-neighbor tour over a stored distance matrix.
//
// Input stream (s_*): s_tuser is the command. A load beat writes one matrix
// entry (row, column, distance); entries outside the matrix are dropped.
// A start beat runs a tour from start_city; a start city at or above the
// city count is dropped without any result.
// Result stream (m_*): one beat per city reached, the start city first with
// leg cost zero, then the closing leg back to the start marked with m_tlast.
// Config channel (cfg_*): city count, always ready. The user is to write it
// only while idle; the block itself does not enforce this.
//
// Timing: a tour issues one matrix read per cycle while it scans, through
// the single read port of the matrix RAM. Each step reads the n entries of
// the current row, drains the compare, decides, and presents the beat. A
// tour closes early, before every city is reached, when it runs out of edges.
// The input is not ready during a tour.
// A stalled result holds in the output register and the sequencer waits.
// Reset clears the sequencer, visited flags, run total, output valid, and
// sets the city count to 16; the matrix holds nothing defined until written.
module nearest_neighbour_tour import nnt_pkg::*; #(
    parameter int MAX_CITIES = MAX_CITIES_DEF,
    parameter int DIST_BITS  = DIST_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // row_city[3:0], col_city[7:4], distance[23:8], start_city[27:24], zero
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   s_tuser,     // command[0]
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // city[3:0], leg_cost[19:4], total_cost[40:20], zero
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic                   m_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [COUNT_W-1:0]     cfg_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready
);

    localparam int CITY_W = $clog2(MAX_CITIES);
    localparam int RAM_AW = 2 * CITY_W;
    localparam int SUM_W  = ((DIST_BITS > TOTAL_W) ? DIST_BITS : TOTAL_W) + 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EMIT   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;
    localparam logic [2:0] ST_CWAIT  = 3'd5;

    // Input fields
    logic [CITY_PORT_W-1:0] in_row, in_col, in_start;
    logic [DIST_PORT_W-1:0] in_dist;

    assign in_row   = s_tdata[3:0];
    assign in_col   = s_tdata[7:4];
    assign in_dist  = s_tdata[23:8];
    assign in_start = s_tdata[27:24];

    // Sequencer and tour state
    logic [2:0]             state_reg, state_next;
    logic [COUNT_W-1:0]     city_count_reg, city_count_next;
    logic [MAX_CITIES-1:0]  visited_reg, visited_next;
    logic [CITY_W-1:0]      cur_reg, cur_next;
    logic [CITY_W-1:0]      start_reg, start_next;
    logic [CITY_W-1:0]      k_reg, k_next;
    logic [TOTAL_W-1:0]     run_reg, run_next;
    logic [CITY_W-1:0]      pend_city_reg, pend_city_next;
    logic [DIST_BITS-1:0]   pend_leg_reg, pend_leg_next;
    logic                   pend_last_reg, pend_last_next;

    // Candidate pipeline alongside the RAM read latency
    logic                   cand_v_reg;
    logic [CITY_W-1:0]      cand_idx_reg;
    logic                   cand_vis_reg;

    // Output register
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [CITY_PORT_W-1:0] m_city_reg, m_city_next;
    logic [LEG_PORT_W-1:0]  m_leg_reg, m_leg_next;
    logic [TOTAL_W-1:0]     m_total_reg, m_total_next;
    logic                   m_last_reg, m_last_next;

    logic [COUNT_EXT_W-1:0] n_eff;
    logic                   in_accept, out_free;
    logic                   load_ok, start_ok, scan_end;

    // RAM ports
    logic                   ram_we;
    logic [RAM_AW-1:0]      ram_waddr, ram_raddr;
    logic [DIST_BITS-1:0]   ram_wdata, ram_rdata;

    // Compare unit
    nnt_scan_ctl_t          scan_ctl;
    logic                   best_found;
    logic [DIST_BITS-1:0]   best_dist;
    logic [CITY_W-1:0]      best_city;

    // Shared saturating adder
    logic [DIST_BITS-1:0]   add_leg;
    logic [SUM_W-1:0]       add_sum;
    logic [TOTAL_W-1:0]     add_sat;

    assign n_eff = (COUNT_EXT_W'(city_count_reg) > COUNT_EXT_W'(MAX_CITIES))
                 ? COUNT_EXT_W'(MAX_CITIES) : COUNT_EXT_W'(city_count_reg);

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    assign load_ok  = (COUNT_EXT_W'(in_row) < COUNT_EXT_W'(MAX_CITIES)) &&
                      (COUNT_EXT_W'(in_col) < COUNT_EXT_W'(MAX_CITIES));
    assign start_ok = COUNT_EXT_W'(in_start) < n_eff;
    assign scan_end = (COUNT_EXT_W'(k_reg) + COUNT_EXT_W'(1)) == n_eff;

    // Matrix writes come straight from load beats
    assign ram_we    = in_accept && (s_tuser == CMD_LOAD) && load_ok;
    assign ram_waddr = {CITY_W'(in_row), CITY_W'(in_col)};
    assign ram_wdata = DIST_BITS'(in_dist);
    // Scan reads the current row; the decide step reads the closing entry
    assign ram_raddr = (state_reg == ST_SCAN) ? {cur_reg, k_reg} : {cur_reg, start_reg};

    nnt_ram #(
        .WIDTH (DIST_BITS),
        .DEPTH (1 << RAM_AW)
    ) u_matrix (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign scan_ctl.clear      = (state_reg == ST_EMIT) && out_free && !pend_last_reg;
    assign scan_ctl.cand_valid = cand_v_reg;

    nnt_scan #(
        .CITY_W    (CITY_W),
        .DIST_BITS (DIST_BITS)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (scan_ctl),
        .cand_idx     (cand_idx_reg),
        .cand_dist    (ram_rdata),
        .cand_visited (cand_vis_reg),
        .found        (best_found),
        .best_dist    (best_dist),
        .best_city    (best_city)
    );

    assign add_leg = (state_reg == ST_CWAIT) ? ram_rdata : best_dist;
    assign add_sum = SUM_W'(run_reg) + SUM_W'(add_leg);
    assign add_sat = (add_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(add_sum);

    always_comb begin
        state_next      = state_reg;
        city_count_next = city_count_reg;
        visited_next    = visited_reg;
        cur_next        = cur_reg;
        start_next      = start_reg;
        k_next          = k_reg;
        run_next        = run_reg;
        pend_city_next  = pend_city_reg;
        pend_leg_next   = pend_leg_reg;
        pend_last_next  = pend_last_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_city_next     = m_city_reg;
        m_leg_next      = m_leg_reg;
        m_total_next    = m_total_reg;
        m_last_next     = m_last_reg;

        if (cfg_valid && cfg_ready) begin
            city_count_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept && (s_tuser == CMD_START) && start_ok) begin
                    start_next     = CITY_W'(in_start);
                    cur_next       = CITY_W'(in_start);
                    visited_next   = '0;
                    visited_next[CITY_W'(in_start)] = 1'b1;
                    run_next       = '0;
                    pend_city_next = CITY_W'(in_start);
                    pend_leg_next  = '0;
                    pend_last_next = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Present the pending result once the output register frees up
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_city_next   = CITY_PORT_W'(pend_city_reg);
                    m_leg_next    = LEG_PORT_W'(pend_leg_reg);
                    m_total_next  = run_reg;
                    m_last_next   = pend_last_reg;
                    k_next        = '0;
                    state_next    = pend_last_reg ? ST_IDLE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                k_next = k_reg + CITY_W'(1);
                if (scan_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (best_found) begin
                    run_next       = add_sat;
                    cur_next       = best_city;
                    visited_next[best_city] = 1'b1;
                    pend_city_next = best_city;
                    pend_leg_next  = best_dist;
                    pend_last_next = 1'b0;
                    state_next     = ST_EMIT;
                end else begin
                    state_next = ST_CWAIT;
                end
            end
            ST_CWAIT: begin
                // Closing leg is added as stored, even without an edge
                run_next       = add_sat;
                cur_next       = start_reg;
                pend_city_next = start_reg;
                pend_leg_next  = ram_rdata;
                pend_last_next = 1'b1;
                state_next     = ST_EMIT;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            city_count_reg <= CITY_COUNT_RESET;
            visited_reg    <= '0;
            cur_reg        <= '0;
            run_reg        <= '0;
            cand_v_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            city_count_reg <= city_count_next;
            visited_reg    <= visited_next;
            cur_reg        <= cur_next;
            run_reg        <= run_next;
            cand_v_reg     <= (state_reg == ST_SCAN);
            m_tvalid_reg   <= m_tvalid_next;
        end
        start_reg     <= start_next;
        k_reg         <= k_next;
        pend_city_reg <= pend_city_next;
        pend_leg_reg  <= pend_leg_next;
        pend_last_reg <= pend_last_next;
        cand_idx_reg  <= k_reg;
        cand_vis_reg  <= visited_reg[k_reg];
        m_city_reg    <= m_city_next;
        m_leg_reg     <= m_leg_next;
        m_total_reg   <= m_total_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_TDATA_W - CITY_PORT_W - LEG_PORT_W - TOTAL_W){1'b0}},
                       m_total_reg, m_leg_reg, m_city_reg};

    // A scan runs to its end without detours
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |=> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("scan left early");

    // The chosen city was not visited yet and has a real edge
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE && best_found) |->
            (!visited_reg[best_city] && best_dist != '0))
        else $error("bad nearest-city choice");

    // The running total never falls within a tour
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE || state_reg == ST_CWAIT) |=> (run_reg >= $past(run_reg)))
        else $error("running total decreased");

    // The closing beat always goes back to the start city
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CWAIT) |=> (pend_last_reg && pend_city_reg == start_reg))
        else $error("closing leg not to start city");

endmodule

### rtl/core/nnt_ram.sv
module nnt_ram import nnt_pkg::*; #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/nnt_scan.sv
module nnt_scan import nnt_pkg::*; #(
    parameter int CITY_W    = 4,
    parameter int DIST_BITS = DIST_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  nnt_scan_ctl_t        ctl,
    input  logic [CITY_W-1:0]    cand_idx,
    input  logic [DIST_BITS-1:0] cand_dist,
    input  logic                 cand_visited,
    output logic                 found,
    output logic [DIST_BITS-1:0] best_dist,
    output logic [CITY_W-1:0]    best_city
);

    logic                 found_reg, found_next;
    logic [DIST_BITS-1:0] best_dist_reg, best_dist_next;
    logic [CITY_W-1:0]    best_city_reg, best_city_next;
    logic                 take;

    // Strict less-than keeps the lowest index on a tie
    assign take = ctl.cand_valid && (cand_dist != '0) && !cand_visited &&
                  (!found_reg || (cand_dist < best_dist_reg));

    always_comb begin
        found_next     = found_reg;
        best_dist_next = best_dist_reg;
        best_city_next = best_city_reg;
        if (ctl.clear) begin
            found_next = 1'b0;
        end else if (take) begin
            found_next     = 1'b1;
            best_dist_next = cand_dist;
            best_city_next = cand_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
        best_dist_reg <= best_dist_next;
        best_city_reg <= best_city_next;
    end

    assign found     = found_reg;
    assign best_dist = best_dist_reg;
    assign best_city = best_city_reg;

endmodule

### test/tb_nearest_neighbour_tour.sv
`timescale 1ns / 1ps

module tb_nearest_neighbour_tour;
    import nnt_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 12;
    localparam int STALL_LIMIT  = 20000;  // cycles without any beat before giving up
    localparam int HOLD_CYCLES  = 1500;   // long receiver hold-off to back up the block
    localparam int CFG_SETTLE   = 32;     // quiet cycles before a city count write
    localparam int END_SETTLE   = 400;    // quiet cycles after the last expected result
    localparam int PHASE_ITEMS  = 24;

    // One city reached on a tour, as carried by a result beat
    typedef struct packed {
        logic [CITY_PORT_W-1:0] city;
        logic [LEG_PORT_W-1:0]  leg;
        logic [TOTAL_W-1:0]     total;
        logic                   last;
    } tour_stop_t;

    // Mirror of the distance matrix and city count; plans each tour and
    // checks the result beats against the planned stops in order.
    class tour_checker;
        logic [DIST_PORT_W-1:0] dist_copy [MAX_CITIES_DEF][MAX_CITIES_DEF];
        logic [COUNT_W-1:0]     city_count;
        tour_stop_t             pending_stops[$];
        int                     errors;

        function new();
            city_count = CITY_COUNT_RESET;
            errors = 0;
            foreach (dist_copy[r, c]) dist_copy[r][c] = '0;
        endfunction

        function void set_city_count(logic [COUNT_W-1:0] value);
            city_count = value;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("%s", msg);
        endfunction

        function logic [TOTAL_W-1:0] add_leg(logic [TOTAL_W-1:0] total,
                                             logic [LEG_PORT_W-1:0] leg);
            logic [TOTAL_W:0] sum;
            sum = {1'b0, total} + leg;
            return (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        endfunction

        function void push_stop(int city, logic [LEG_PORT_W-1:0] leg,
                                logic [TOTAL_W-1:0] total, logic last);
            tour_stop_t s;
            s.city  = city[CITY_PORT_W-1:0];
            s.leg   = leg;
            s.total = total;
            s.last  = last;
            pending_stops.insert(pending_stops.size(), s);
        endfunction

        // Apply one accepted input beat: store a load, or plan a whole tour.
        function void note_command(logic cmd, logic [3:0] row, logic [3:0] col,
                                   logic [DIST_PORT_W-1:0] dist_val, logic [3:0] start);
            int                     n;
            int                     cur;
            int                     best_city;
            logic [DIST_PORT_W-1:0] best;
            logic [DIST_PORT_W-1:0] d;
            logic                   found;
            logic [MAX_CITIES_DEF-1:0] visited;
            logic [TOTAL_W-1:0]     total;
            if (cmd == CMD_LOAD) begin
                dist_copy[row][col] = dist_val;
                return;
            end
            n = (city_count > MAX_CITIES_DEF) ? MAX_CITIES_DEF : int'(city_count);
            if (int'(start) >= n) return;
            visited = '0;
            visited[start] = 1'b1;
            total = '0;
            cur = start;
            push_stop(cur, '0, total, 1'b0);
            found = 1'b1;
            while (found) begin
                found = 1'b0;
                best = '0;
                best_city = 0;
                // strict less-than keeps the lowest index on a tie
                for (int k = 0; k < n; k++) begin
                    d = dist_copy[cur][k];
                    if (d != 0 && !visited[k] && (!found || d < best)) begin
                        found = 1'b1;
                        best = d;
                        best_city = k;
                    end
                end
                if (found) begin
                    total = add_leg(total, best);
                    cur = best_city;
                    visited[cur] = 1'b1;
                    push_stop(cur, best, total, 1'b0);
                end
            end
            // closing leg goes back as stored, even with no edge
            d = dist_copy[cur][start];
            total = add_leg(total, d);
            push_stop(start, d, total, 1'b1);
        endfunction

        function void check_stop(logic [CITY_PORT_W-1:0] city, logic [LEG_PORT_W-1:0] leg,
                                 logic [TOTAL_W-1:0] total, logic last);
            tour_stop_t want;
            tour_stop_t got;
            got.city  = city;
            got.leg   = leg;
            got.total = total;
            got.last  = last;
            if (pending_stops.size() == 0) begin
                flag($sformatf("unexpected result: city %0d leg %0d total %0d last %0b",
                               city, leg, total, last));
                return;
            end
            want = pending_stops.pop_front();
            if (got !== want)
                flag($sformatf({"mismatch: expected city %0d leg %0d total %0d last %0b, ",
                                "got city %0d leg %0d total %0d last %0b"},
                               want.city, want.leg, want.total, want.last,
                               city, leg, total, last));
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic [S_TDATA_W-1:0] s_tdata;     // row_city, col_city, distance, start_city, zero
    logic                 s_tuser;     // command
    logic                 s_tvalid;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;     // city, leg_cost, total_cost, zero
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [COUNT_W-1:0]   cfg_data;
    logic                 cfg_valid;
    logic                 cfg_ready;

    tour_checker tours = new();
    int          burst_left = 0;
    int          idle_cycles = 0;

    nearest_neighbour_tour dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    initial aclk = 1'b0;
    always #CLK_HALF aclk = ~aclk;

    // Feed the planner every accepted input beat and city count write,
    // and check every accepted result beat.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            tours.note_command(s_tuser, s_tdata[3:0], s_tdata[7:4], s_tdata[23:8],
                               s_tdata[27:24]);
        if (aresetn && cfg_valid && cfg_ready)
            tours.set_city_count(cfg_data);
        if (aresetn && m_tvalid && m_tready)
            tours.check_stop(m_tdata[3:0], m_tdata[19:4], m_tdata[40:20], m_tlast);
    end

    // Abort when no beat moves on any channel for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: cycle through stall patterns, with two long hold-offs while
    // the sender keeps offering beats, so the block backs up and stalls.
    initial begin
        int cyc;
        cyc = 0;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc == 3000 || cyc == 25000) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                cyc += HOLD_CYCLES;
            end else begin
                case ((cyc / 200) % 4)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= cyc[0];
                    default: m_tready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // Mix of no-edge zeros, the maximum, tiny values that tie, and anything.
    function automatic logic [DIST_PORT_W-1:0] pick_distance();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1: return '0;
            2: return '1;
            3, 4: return DIST_PORT_W'($urandom_range(1, 4));
            default: return DIST_PORT_W'($urandom);
        endcase
    endfunction

    // Offer one input beat; bursts of random length with random gaps between.
    task automatic send_beat(input logic cmd, input logic [3:0] row, input logic [3:0] col,
                             input logic [DIST_PORT_W-1:0] dist_val, input logic [3:0] start);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = $urandom_range(0, 12);
            if (gap > 0 && $urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tdata  <= {4'b0, start, dist_val, col, row};
        s_tuser  <= cmd;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_load(input int row, input int col,
                             input logic [DIST_PORT_W-1:0] dist_val);
        send_beat(CMD_LOAD, row[3:0], col[3:0], dist_val, 4'($urandom));
    endtask

    task automatic send_start(input int start);
        send_beat(CMD_START, 4'($urandom), 4'($urandom), DIST_PORT_W'($urandom), start[3:0]);
    endtask

    // Stop offering, then wait for every planned stop plus a settle time.
    task automatic drain_results(input int settle);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tours.pending_stops.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_city_count(input int count);
        drain_results(CFG_SETTLE);
        cfg_data  <= count[COUNT_W-1:0];
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // One random beat: mostly loads aimed inside the cities in use and starts
    // from a city in use; now and then anything the fields allow.
    task automatic random_beat(input int count);
        int lim;
        int row;
        int col;
        lim = (count > MAX_CITIES_DEF) ? MAX_CITIES_DEF : count;
        if ($urandom_range(0, 99) < 65) begin
            if (lim > 0 && $urandom_range(0, 9) < 7) begin
                row = $urandom_range(0, lim - 1);
                col = $urandom_range(0, lim - 1);
            end else begin
                row = $urandom_range(0, 15);
                col = $urandom_range(0, 15);
            end
            send_load(row, col, pick_distance());
        end else if (lim > 0 && $urandom_range(0, 99) < 85) begin
            send_start($urandom_range(0, lim - 1));
        end else begin
            send_start($urandom_range(0, 15));
        end
    endtask

    initial begin
        int phase_counts [10];
        aresetn   = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_LOAD;
        s_tvalid  = 1'b0;
        cfg_data  = '0;
        cfg_valid = 1'b0;
        phase_counts = '{16, 2, 7, 17, 1, 12, 0, 31, 16, 0};
        phase_counts[9] = $urandom_range(0, 31);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill the whole matrix first so no tour ever reads an unwritten entry.
        for (int r = 0; r < MAX_CITIES_DEF; r++)
            for (int c = 0; c < MAX_CITIES_DEF; c++)
                send_load(r, c, pick_distance());

        // Two equal edges out of city 0; if shortest, the lower index must win.
        send_load(0, 3, 5);
        send_load(0, 9, 5);
        send_load(0, 1, 0);
        send_load(0, 0, 0);
        send_load(15, 15, '1);
        send_start(0);
        send_start(15);

        // Two cities: city 0 has no edge to 1, so its tour closes at once.
        write_city_count(2);
        send_start(0);
        send_start(1);
        send_start(2);
        send_start(15);

        // One city: start, then a closing leg with no edge.
        write_city_count(1);
        send_start(0);
        send_start(1);

        // No cities: every start is dropped.
        write_city_count(0);
        send_start(0);

        // Count above the matrix size acts as the full matrix.
        write_city_count(31);
        send_start(15);

        for (int p = 0; p < 10; p++) begin
            write_city_count(phase_counts[p]);
            repeat (PHASE_ITEMS) random_beat(phase_counts[p]);
        end

        drain_results(END_SETTLE);
        if (tours.pending_stops.size() != 0)
            tours.flag($sformatf("%0d expected results never arrived",
                                 tours.pending_stops.size()));
        if (tours.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/nnt_pkg.sv
rtl/core/nnt_ram.sv
rtl/core/nnt_scan.sv
rtl/core/nearest_neighbour_tour.sv
test/tb_nearest_neighbour_tour.sv
